FILE: hdl/rfle_pkg.sv
// Shared types and constants for the repeat-flag LEB128 encoder.
// No dependencies.
`default_nettype none

package rfle_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned DIGIT_W    = 8;
  localparam int unsigned GROUP_BITS = 7;
  localparam int unsigned CMP_STEPS  = VALUE_W / DIGIT_W;
  localparam int unsigned CNT_W      = $clog2(CMP_STEPS);

  localparam logic       KIND_FLAG = 1'b0;
  localparam logic       KIND_BYTE = 1'b1;
  localparam logic [7:0] CONT_BIT  = 8'h80;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload;
    logic       last;
  } token_t;

endpackage

`default_nettype wire

FILE: hdl/rfle_out_reg.sv
// Output holding register for encoder tokens.
// Depends on rfle_pkg.
`default_nettype none

module rfle_out_reg
  import rfle_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   load,
  input  wire token_t load_tok,
  output logic        can_load,
  input  wire logic   out_tready,
  output logic        out_tvalid,
  output token_t      out_tok
);

  logic   valid_r;
  token_t tok_r;

  assign can_load   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tok    = tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      tok_r <= load_tok;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/repeat_flag_leb128_encoder_top.sv
// Repeat-flag encoder with LEB128 varint output for 32-bit values.
// Depends on rfle_pkg and rfle_out_reg.
//
//  channel | ports     | tdata                  | tuser          | tlast
//  input   | in_t*     | [31:0] value           | -              | -
//  output  | out_t*    | [7:0] payload          | [0] token_kind | last
//
// First value after reset: stored as reference, no output.
// Later values: accepted, then compared (one byte per cycle through
// a rotating shift register), then one cycle per token unless the output
// stalls: 1 flag token, plus 1 to 5 LEB128 bytes if the value changed.
// Output stalls hold the sequencer; the next item is taken while the
// last token still waits in the output register.
// Reset is synchronous, active low, and clears the reference.
`default_nettype none

module repeat_flag_leb128_encoder_top
  import rfle_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] payload
  output logic             out_tuser,  // [0] token_kind
  output logic             out_tlast
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CMP   = 2'd1;
  localparam logic [1:0] ST_FLAG  = 2'd2;
  localparam logic [1:0] ST_BYTES = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               have_ref_r, have_ref_nxt;
  logic               diff_r, diff_nxt;
  logic [VALUE_W-1:0] ref_r, ref_nxt;
  logic [VALUE_W-1:0] sh_r, sh_nxt;

  logic               in_xfer;
  logic               can_load;
  logic               load;
  token_t             load_tok;
  token_t             out_tok;
  logic [VALUE_W-1:0] rest;
  logic               rest_zero;

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign rest      = sh_r >> GROUP_BITS;
  assign rest_zero = (rest == '0);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    have_ref_nxt = have_ref_r;
    diff_nxt     = diff_r;
    ref_nxt      = ref_r;
    sh_nxt       = sh_r;
    load         = 1'b0;
    load_tok     = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (!have_ref_r) begin
            ref_nxt      = in_tdata;
            have_ref_nxt = 1'b1;
          end else begin
            sh_nxt    = in_tdata;
            cnt_nxt   = '0;
            diff_nxt  = 1'b0;
            state_nxt = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        // compare low byte, rotate both words so they return intact
        diff_nxt = diff_r || (sh_r[DIGIT_W-1:0] != ref_r[DIGIT_W-1:0]);
        sh_nxt   = {sh_r[DIGIT_W-1:0], sh_r[VALUE_W-1:DIGIT_W]};
        ref_nxt  = {ref_r[DIGIT_W-1:0], ref_r[VALUE_W-1:DIGIT_W]};
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(CMP_STEPS - 1)) begin
          state_nxt = ST_FLAG;
        end
      end
      ST_FLAG: begin
        load_tok.kind    = KIND_FLAG;
        load_tok.payload = {7'd0, diff_r};
        load_tok.last    = !diff_r;
        if (can_load) begin
          load = 1'b1;
          if (diff_r) begin
            ref_nxt   = sh_r;
            state_nxt = ST_BYTES;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_BYTES: begin
        load_tok.kind    = KIND_BYTE;
        load_tok.payload = {1'b0, sh_r[GROUP_BITS-1:0]} | (rest_zero ? 8'd0 : CONT_BIT);
        load_tok.last    = rest_zero;
        if (can_load) begin
          load   = 1'b1;
          sh_nxt = rest;
          if (rest_zero) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= '0;
      have_ref_r <= 1'b0;
      diff_r     <= 1'b0;
      ref_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      have_ref_r <= have_ref_nxt;
      diff_r     <= diff_nxt;
      ref_r      <= ref_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
  end

  rfle_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .load_tok   (load_tok),
    .can_load   (can_load),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tok    (out_tok)
  );

  assign out_tdata = out_tok.payload;
  assign out_tuser = out_tok.kind;
  assign out_tlast = out_tok.last;

endmodule

`default_nettype wire
